[sv/assert_macros.svh]
// Assertion macros shared by the scanner RTL.
// Each macro expects clk and rst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition that must hold on every clock edge out of reset.
`define XCPS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define XCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define XCPS_ASSERT_ALWAYS(lbl, cond, msg)
`define XCPS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/xcps_pkg.sv]
`timescale 1ns / 1ps
// Shared types, opcode constants and the start classifier for the code scanner.
// No dependencies; used by xcps_scan_core and x86_code_privilege_scanner.
package xcps_pkg;

    localparam int CNT_W   = 21;
    localparam int CNT_NUM = 7;
    // min(MAX_CODE_BYTES, 2^21 - 1)
    localparam logic [CNT_W-1:0] CNT_CAP = 21'd1048576;

    // counter slots
    localparam int CNT_SAFE    = 0;
    localparam int CNT_RESTR   = 1;
    localparam int CNT_PRIV    = 2;
    localparam int CNT_SYSCALL = 3;
    localparam int CNT_IO      = 4;
    localparam int CNT_ICALL   = 5;
    localparam int CNT_IJUMP   = 6;

    // privilege levels
    localparam logic [1:0] LVL_SANDBOX = 2'd0;
    localparam logic [1:0] LVL_USER    = 2'd1;
    localparam logic [1:0] LVL_DRIVER  = 2'd2;
    localparam logic [1:0] LVL_KERNEL  = 2'd3;

    // opcodes
    localparam logic [7:0] OP_CLI       = 8'hFA;
    localparam logic [7:0] OP_STI       = 8'hFB;
    localparam logic [7:0] OP_HLT       = 8'hF4;
    localparam logic [7:0] OP_TWO_BYTE  = 8'h0F;
    localparam logic [7:0] OP_INT       = 8'hCD;
    localparam logic [7:0] OP_INTO      = 8'hCE;
    localparam logic [7:0] OP_IO_IMM    = 8'hE4;
    localparam logic [7:0] OP_IO_DX     = 8'hEC;
    localparam logic [7:0] OP_IO_MASK   = 8'hFC;
    localparam logic [7:0] OP_GRP5      = 8'hFF;
    localparam logic [7:0] OP2_GRP7     = 8'h01;
    localparam logic [7:0] OP2_SYSCALL  = 8'h05;
    localparam logic [7:0] OP2_MOV_RCR  = 8'h20;
    localparam logic [7:0] OP2_MOV_WCR  = 8'h22;
    localparam logic [7:0] OP2_WRMSR    = 8'h30;
    localparam logic [7:0] OP2_RDMSR    = 8'h32;
    localparam logic [7:0] OP2_SYSENTER = 8'h34;
    localparam logic [7:0] MODRM_REG_MASK = 8'h38;
    localparam logic [7:0] GRP7_PRIV_MAX  = 8'h18;
    localparam logic [2:0] GRP5_CALL_IND  = 3'd2;
    localparam logic [2:0] GRP5_JMP_IND   = 3'd4;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] safe_total;
        logic [CNT_W-1:0] restricted_total;
        logic [CNT_W-1:0] privileged_total;
        logic [CNT_W-1:0] syscall_total;
        logic [CNT_W-1:0] port_io_total;
        logic [CNT_W-1:0] indirect_call_total;
        logic [CNT_W-1:0] indirect_jump_total;
        logic [1:0]       needed_level;
        logic             approved;
    } out_item_t;

    typedef logic [CNT_NUM-1:0][CNT_W-1:0] cnt_vec_t;

    typedef struct packed {
        logic [1:0]         len;
        logic [CNT_NUM-1:0] hits;
    } start_class_t;

    function automatic start_class_t classify(input logic [7:0] b0,
                                              input logic [7:0] b1,
                                              input logic [7:0] b2);
        start_class_t r;
        logic [2:0]   modrm_reg;
        r         = '0;
        r.len     = 2'd1;
        modrm_reg = b1[5:3];
        if (b0 == OP_CLI || b0 == OP_STI || b0 == OP_HLT) begin
            r.hits[CNT_PRIV] = 1'b1;
        end else if (b0 == OP_TWO_BYTE) begin
            if (b1 == OP2_GRP7 && (b2 & MODRM_REG_MASK) <= GRP7_PRIV_MAX) begin
                r.hits[CNT_PRIV] = 1'b1;
                r.len            = 2'd3;
            end else if (b1 == OP2_MOV_RCR || b1 == OP2_MOV_WCR) begin
                r.hits[CNT_PRIV] = 1'b1;
                r.len            = 2'd3;
            end else if (b1 == OP2_WRMSR || b1 == OP2_RDMSR) begin
                r.hits[CNT_PRIV] = 1'b1;
                r.len            = 2'd2;
            end else if (b1 == OP2_SYSCALL) begin
                r.hits[CNT_RESTR]   = 1'b1;
                r.hits[CNT_SYSCALL] = 1'b1;
                r.len               = 2'd2;
            end else if (b1 == OP2_SYSENTER) begin
                r.hits[CNT_RESTR] = 1'b1;
                r.len             = 2'd2;
            end else begin
                r.hits[CNT_SAFE] = 1'b1;
            end
        end else if (b0 == OP_INT) begin
            r.hits[CNT_RESTR] = 1'b1;
            r.len             = 2'd2;
        end else if (b0 == OP_INTO) begin
            r.hits[CNT_RESTR] = 1'b1;
        end else if ((b0 & OP_IO_MASK) == OP_IO_IMM || (b0 & OP_IO_MASK) == OP_IO_DX) begin
            r.hits[CNT_RESTR] = 1'b1;
            r.hits[CNT_IO]    = 1'b1;
        end else begin
            r.hits[CNT_SAFE] = 1'b1;
        end
        // FF /2 and FF /4 are counted on top of the class
        if (b0 == OP_GRP5) begin
            r.hits[CNT_ICALL] = (modrm_reg == GRP5_CALL_IND);
            r.hits[CNT_IJUMP] = (modrm_reg == GRP5_JMP_IND);
        end
        return r;
    endfunction

endpackage

[sv/xcps_scan_core.sv]
`timescale 1ns / 1ps
// Byte window, instruction-start tracking and saturating class counters.
// Depends on xcps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xcps_scan_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  xcps_pkg::in_item_t item,
    output xcps_pkg::cnt_vec_t totals
);

    logic [7:0] win0_reg, win0_next;
    logic [7:0] win1_reg, win1_next;
    logic [1:0] fill_reg, fill_next;
    xcps_pkg::cnt_vec_t cnt_reg, cnt_next;

    xcps_pkg::start_class_t cls_a, cls_f1, cls_f2;
    logic       va, vf1, vf2;
    logic [7:0] p0, p1, f1_b1;
    logic [1:0] pf;
    logic [1:0] inc [xcps_pkg::CNT_NUM];
    logic [xcps_pkg::CNT_W:0] sum [xcps_pkg::CNT_NUM];

    // full start: two held bytes plus the incoming one
    always_comb
    begin
        va    = (fill_reg == 2'd2);
        cls_a = xcps_pkg::classify(win0_reg, win1_reg, item.code_byte);
        if (fill_reg == 2'd2) begin
            unique case (cls_a.len)
                2'd1:
                begin
                    p0 = win1_reg;
                    p1 = item.code_byte;
                    pf = 2'd2;
                end
                2'd2:
                begin
                    p0 = item.code_byte;
                    p1 = 8'h00;
                    pf = 2'd1;
                end
                default:
                begin
                    p0 = 8'h00;
                    p1 = 8'h00;
                    pf = 2'd0;
                end
            endcase
        end else if (fill_reg == 2'd1) begin
            p0 = win0_reg;
            p1 = item.code_byte;
            pf = 2'd2;
        end else begin
            p0 = item.code_byte;
            p1 = 8'h00;
            pf = 2'd1;
        end
    end

    // flush of pending starts on the last byte, bytes past the end read zero
    always_comb
    begin
        f1_b1  = (pf == 2'd2) ? p1 : 8'h00;
        cls_f1 = xcps_pkg::classify(p0, f1_b1, 8'h00);
        cls_f2 = xcps_pkg::classify(p1, 8'h00, 8'h00);
        vf1    = item.is_last && (pf != 2'd0);
        vf2    = item.is_last && (pf == 2'd2) && (cls_f1.len == 2'd1);
    end

    always_comb
    begin
        for (int i = 0; i < xcps_pkg::CNT_NUM; i++) begin
            inc[i] = {1'b0, cls_a.hits[i] & va} + {1'b0, cls_f1.hits[i] & vf1}
                   + {1'b0, cls_f2.hits[i] & vf2};
            sum[i] = {1'b0, cnt_reg[i]} + {{(xcps_pkg::CNT_W - 1){1'b0}}, inc[i]};
            totals[i] = (sum[i] > {1'b0, xcps_pkg::CNT_CAP}) ? xcps_pkg::CNT_CAP
                                                               : sum[i][xcps_pkg::CNT_W-1:0];
        end
    end

    always_comb
    begin
        win0_next = win0_reg;
        win1_next = win1_reg;
        fill_next = fill_reg;
        cnt_next  = cnt_reg;
        if (step_en) begin
            if (item.is_last) begin
                win0_next = 8'h00;
                win1_next = 8'h00;
                fill_next = 2'd0;
                cnt_next  = '0;
            end else begin
                win0_next = p0;
                win1_next = p1;
                fill_next = pf;
                cnt_next  = totals;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            win0_reg <= 8'h00;
            win1_reg <= 8'h00;
            fill_reg <= 2'd0;
            cnt_reg  <= '0;
        end else begin
            win0_reg <= win0_next;
            win1_reg <= win1_next;
            fill_reg <= fill_next;
            cnt_reg  <= cnt_next;
        end
    end

    `XCPS_ASSERT_ALWAYS(a_fill_range, fill_reg != 2'd3, "window fill out of range")
    `XCPS_ASSERT_NEXT(a_clear_after_last, step_en && item.is_last, fill_reg == 2'd0 && cnt_reg == '0, "state not cleared after last byte")
    `XCPS_ASSERT_ALWAYS(a_cap, cnt_reg[xcps_pkg::CNT_SAFE] <= xcps_pkg::CNT_CAP && cnt_reg[xcps_pkg::CNT_RESTR] <= xcps_pkg::CNT_CAP && cnt_reg[xcps_pkg::CNT_PRIV] <= xcps_pkg::CNT_CAP, "counter beyond cap")

endmodule

[sv/x86_code_privilege_scanner.sv]
`timescale 1ns / 1ps
// Code privilege scanner: streams code bytes, returns one summary per section.
// Channels: in_valid/in_stall carry in_item (code_byte, is_last); out_valid/
// out_stall carry out_item with seven saturating counts, needed_level and
// approved. cfg_wr_en/cfg_wr_data write allowed_level (reset value user).
// Throughput: one byte per cycle unless a last byte is held (see Stall). Each
// accepted item is registered, then the window/classifier/counter logic updates
// state from it; a byte marked is_last loads the summary shown on out_valid.
// Only bytes with is_last produce an item; the counters and window are cleared
// with it so the next section starts fresh.
// Reset: counters, window and both valid flags clear; allowed_level returns
// to user.
// Stall: a waiting summary is held in the output register. Non-last bytes keep
// flowing while it waits; a following last byte is held in the input register
// (in_stall high) until the output register is free.
// Depends on xcps_pkg, xcps_scan_core and assert_macros.svh.
`include "assert_macros.svh"

module x86_code_privilege_scanner (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  xcps_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output xcps_pkg::out_item_t out_item,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data
);

    logic               ireg_valid_reg, ireg_valid_next;
    xcps_pkg::in_item_t ireg_item_reg, ireg_item_next;
    logic               out_valid_reg, out_valid_next;
    xcps_pkg::out_item_t out_item_reg, out_item_next;
    logic [1:0]         allowed_reg, allowed_next;

    logic               res_free, step_en, in_fire, load;
    logic [1:0]         level;
    xcps_pkg::cnt_vec_t totals;

    xcps_scan_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (ireg_item_reg),
        .totals  (totals)
    );

    assign res_free = !out_valid_reg || !out_stall;
    assign step_en  = ireg_valid_reg && (!ireg_item_reg.is_last || res_free);
    assign in_stall = ireg_valid_reg && !step_en;
    assign in_fire  = in_valid && !in_stall;
    assign load     = step_en && ireg_item_reg.is_last;

    always_comb
    begin
        priority if (totals[xcps_pkg::CNT_PRIV] != '0) begin
            level = xcps_pkg::LVL_KERNEL;
        end else if (totals[xcps_pkg::CNT_IO] != '0) begin
            level = xcps_pkg::LVL_DRIVER;
        end else if (totals[xcps_pkg::CNT_SYSCALL] != '0) begin
            level = xcps_pkg::LVL_USER;
        end else begin
            level = xcps_pkg::LVL_SANDBOX;
        end
    end

    always_comb
    begin
        ireg_valid_next = ireg_valid_reg;
        ireg_item_next  = ireg_item_reg;
        if (in_fire) begin
            ireg_valid_next = 1'b1;
            ireg_item_next  = in_item;
        end else if (step_en) begin
            ireg_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        if (load) begin
            out_valid_next                     = 1'b1;
            out_item_next.safe_total           = totals[xcps_pkg::CNT_SAFE];
            out_item_next.restricted_total     = totals[xcps_pkg::CNT_RESTR];
            out_item_next.privileged_total     = totals[xcps_pkg::CNT_PRIV];
            out_item_next.syscall_total        = totals[xcps_pkg::CNT_SYSCALL];
            out_item_next.port_io_total        = totals[xcps_pkg::CNT_IO];
            out_item_next.indirect_call_total  = totals[xcps_pkg::CNT_ICALL];
            out_item_next.indirect_jump_total  = totals[xcps_pkg::CNT_IJUMP];
            out_item_next.needed_level         = level;
            out_item_next.approved             = (level <= allowed_reg);
        end

        allowed_next = cfg_wr_en ? cfg_wr_data : allowed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ireg_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            allowed_reg    <= xcps_pkg::LVL_USER;
        end else begin
            ireg_valid_reg <= ireg_valid_next;
            out_valid_reg  <= out_valid_next;
            allowed_reg    <= allowed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ireg_item_reg <= ireg_item_next;
        out_item_reg  <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `XCPS_ASSERT_NEXT(a_last_loads, load, out_valid_reg, "summary not loaded after last byte")
    `XCPS_ASSERT_ALWAYS(a_no_overwrite, !(load && out_valid_reg && out_stall), "pending summary overwritten")
    `XCPS_ASSERT_ALWAYS(a_level_priv, !out_valid_reg || ((out_item_reg.needed_level == xcps_pkg::LVL_KERNEL) == (out_item_reg.privileged_total != '0)), "needed level disagrees with privileged count")

endmodule
